// ===== hw/rtl/pls_pkg.sv =====
// Shared types for the packet latency statistics block.
// Defines the input and result transfer structs; no dependencies.
`default_nettype none

package pls_pkg;

    localparam logic [31:0] LAT_NONE = 32'hFFFF_FFFF;

    localparam logic [1:0] CLS_UP_DATA  = 2'd0;
    localparam logic [1:0] CLS_UP_CLOSE = 2'd1;
    localparam logic [1:0] CLS_UP_OPEN  = 2'd2;
    localparam logic [1:0] CLS_DOWN     = 2'd3;

    localparam logic [1:0] PKT_DATA  = 2'd0;
    localparam logic [1:0] PKT_CLOSE = 2'd1;

    localparam logic MODE_RECORD = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [63:0] start_time;
        logic [63:0] end_time;
        logic [1:0]  packet_type;
        logic        upstream;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  class_index;
        logic [31:0] packet_count;
        logic [31:0] min_time;
        logic [31:0] max_time;
        logic [31:0] mean_time;
        logic        last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hw/rtl/packet_latency_stats_core.sv =====
// Packet latency statistics core: per-class count, sum, min, max and mean.
// Depends on pls_pkg for the transfer structs and class codes.
`default_nettype none

// A record transfer (mode 0) takes the item and forms the 32-bit latency in ST_IDLE, then
// updates the class entry in ST_UPDATE; the next item is taken in the cycle after that.
// A report transfer (mode 1) emits NUM_CLASSES results in class order, the final one
// flagged with last, and clears each class as its result is loaded. Each result takes
// one load, 64 steps of a shared restoring divider producing one quotient bit per cycle,
// then one load of the output register, which waits while the output is stalled.
// The input is stalled for the whole report.
// The output register holds one result and lets the core keep working while it waits.
module packet_latency_stats_core #(
    parameter int NUM_CLASSES = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  pls_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output pls_pkg::t_out_item  o_out_data
);

    localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(NUM_CLASSES - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_UPDATE   = 3'd1;
    localparam logic [2:0] ST_DIV_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV_RUN  = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;

    logic [2:0]    r_state;
    logic [CW-1:0] r_idx;
    logic [31:0]   r_lat;
    logic [5:0]    r_step;
    logic [63:0]   r_dvd;
    logic [31:0]   r_dvs;
    logic [31:0]   r_rem;
    logic [31:0]   r_quo;

    logic [31:0] r_cnt [NUM_CLASSES];
    logic [63:0] r_sum [NUM_CLASSES];
    logic [31:0] r_min [NUM_CLASSES];
    logic [31:0] r_max [NUM_CLASSES];

    logic               r_out_valid;
    pls_pkg::t_out_item r_out;

    logic [1:0]  n_cls;
    logic        n_cls_ok;
    logic [32:0] n_rem_sh;
    logic        n_qbit;
    logic        out_free;
    logic        in_xfer;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        if (!i_in_data.upstream) begin
            n_cls = pls_pkg::CLS_DOWN;
        end else if (i_in_data.packet_type == pls_pkg::PKT_DATA) begin
            n_cls = pls_pkg::CLS_UP_DATA;
        end else if (i_in_data.packet_type == pls_pkg::PKT_CLOSE) begin
            n_cls = pls_pkg::CLS_UP_CLOSE;
        end else begin
            n_cls = pls_pkg::CLS_UP_OPEN;
        end
        n_cls_ok = (32'(n_cls) < 32'(NUM_CLASSES));
    end

    always_comb begin
        n_rem_sh = {r_rem, r_dvd[63]};
        n_qbit   = (n_rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_cnt[c] <= '0;
                r_sum[c] <= '0;
                r_min[c] <= pls_pkg::LAT_NONE;
                r_max[c] <= '0;
            end
        end else begin
            if ((r_state == ST_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_in_data.mode == pls_pkg::MODE_REPORT) begin
                            r_idx   <= '0;
                            r_state <= ST_DIV_LOAD;
                        end else if (n_cls_ok) begin
                            r_lat   <= i_in_data.end_time[31:0] - i_in_data.start_time[31:0];
                            r_idx   <= CW'(n_cls);
                            r_state <= ST_UPDATE;
                        end
                    end
                end
                ST_UPDATE: begin
                    r_cnt[r_idx] <= r_cnt[r_idx] + 32'd1;
                    r_sum[r_idx] <= r_sum[r_idx] + {32'd0, r_lat};
                    if (r_lat > r_max[r_idx]) begin
                        r_max[r_idx] <= r_lat;
                    end
                    if (r_lat < r_min[r_idx]) begin
                        r_min[r_idx] <= r_lat;
                    end
                    r_state <= ST_IDLE;
                end
                ST_DIV_LOAD: begin
                    r_dvd   <= r_sum[r_idx];
                    r_dvs   <= r_cnt[r_idx];
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_step  <= '0;
                    r_state <= ST_DIV_RUN;
                end
                ST_DIV_RUN: begin
                    r_rem  <= n_qbit ? 32'(n_rem_sh - {1'b0, r_dvs}) : n_rem_sh[31:0];
                    r_quo  <= {r_quo[30:0], n_qbit};
                    r_dvd  <= {r_dvd[62:0], 1'b0};
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd63) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out.class_index  <= 2'(r_idx);
                        r_out.packet_count <= r_cnt[r_idx];
                        r_out.min_time     <= r_min[r_idx];
                        r_out.max_time     <= r_max[r_idx];
                        r_out.mean_time    <= (r_dvs == 32'd0) ? 32'd0 : r_quo;
                        r_out.last         <= (r_idx == LAST_IDX);
                        r_cnt[r_idx]       <= '0;
                        r_sum[r_idx]       <= '0;
                        r_min[r_idx]       <= pls_pkg::LAT_NONE;
                        r_max[r_idx]       <= '0;
                        if (r_idx == LAST_IDX) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= ST_DIV_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== bench/packet_latency_stats_core_tb.sv =====
// Testbench for packet_latency_stats_core: directed and random record/report transfers.
// A scoreboard class predicts per-class count/min/max/mean and checks each result transfer.
// Depends on pls_pkg and the packet_latency_stats_core RTL.

module packet_latency_stats_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLASSES        = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int PHASE_ITEMS    = 49;

    localparam logic [1:0] PKT_OPEN  = 2'd2;
    localparam logic [1:0] PKT_OTHER = 2'd3;

    class latency_scoreboard;
        logic [31:0] cls_count [CLASSES];
        logic [63:0] cls_sum   [CLASSES];
        logic [31:0] cls_min   [CLASSES];
        logic [31:0] cls_max   [CLASSES];
        pls_pkg::t_out_item pending_results [$];
        int unsigned mismatches;
        int unsigned records_seen;
        int unsigned reports_seen;
        int unsigned results_checked;

        function new();
            mismatches      = 0;
            records_seen    = 0;
            reports_seen    = 0;
            results_checked = 0;
            clear_classes();
        endfunction

        function void clear_classes();
            for (int c = 0; c < CLASSES; c++) begin
                cls_count[c] = '0;
                cls_sum[c]   = '0;
                cls_min[c]   = pls_pkg::LAT_NONE;
                cls_max[c]   = '0;
            end
        endfunction

        function logic [1:0] class_of(input pls_pkg::t_in_item it);
            if (!it.upstream) begin
                return pls_pkg::CLS_DOWN;
            end
            case (it.packet_type)
                pls_pkg::PKT_DATA:  return pls_pkg::CLS_UP_DATA;
                pls_pkg::PKT_CLOSE: return pls_pkg::CLS_UP_CLOSE;
                default:            return pls_pkg::CLS_UP_OPEN;
            endcase
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void note_transfer(input pls_pkg::t_in_item it);
            logic [63:0] span;
            logic [63:0] quot;
            logic [31:0] lat;
            logic [1:0]  cls;
            pls_pkg::t_out_item res;
            if (it.mode == pls_pkg::MODE_RECORD) begin
                span = it.end_time - it.start_time;
                lat  = span[31:0];
                cls  = class_of(it);
                cls_count[cls] = cls_count[cls] + 32'd1;
                cls_sum[cls]   = cls_sum[cls] + {32'd0, lat};
                if (lat > cls_max[cls]) begin
                    cls_max[cls] = lat;
                end
                if (lat < cls_min[cls]) begin
                    cls_min[cls] = lat;
                end
                records_seen++;
            end else begin
                for (int c = 0; c < CLASSES; c++) begin
                    quot = '0;
                    if (cls_count[c] != 0) begin
                        quot = cls_sum[c] / {32'd0, cls_count[c]};
                    end
                    res.class_index  = 2'(c);
                    res.packet_count = cls_count[c];
                    res.min_time     = cls_min[c];
                    res.max_time     = cls_max[c];
                    res.mean_time    = quot[31:0];
                    res.last         = (c == CLASSES - 1);
                    pending_results.push_back(res);
                end
                clear_classes();
                reports_seen++;
            end
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(input pls_pkg::t_out_item got);
            pls_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending: class_index %0d", got.class_index);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            compare_field("class_index",  32'(want.class_index), 32'(got.class_index));
            compare_field("packet_count", want.packet_count,     got.packet_count);
            compare_field("min_time",     want.min_time,         got.min_time);
            compare_field("max_time",     want.max_time,         got.max_time);
            compare_field("mean_time",    want.mean_time,        got.mean_time);
            compare_field("last",         32'(want.last),        32'(got.last));
        endfunction
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    pls_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    pls_pkg::t_out_item o_out_data;
    int unsigned        send_idle_pct  = 33;
    int unsigned        recv_stall_pct = 54;
    int unsigned        quiet_cycles   = 0;
    latency_scoreboard  board;

    packet_latency_stats_core #(
        .NUM_CLASSES(CLASSES)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_result(o_out_data);
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic pls_pkg::t_in_item record_item(input logic [63:0] s,
                                                      input logic [63:0] e,
                                                      input logic [1:0] kind,
                                                      input logic up);
        pls_pkg::t_in_item it;
        it.mode        = pls_pkg::MODE_RECORD;
        it.start_time  = s;
        it.end_time    = e;
        it.packet_type = kind;
        it.upstream    = up;
        return it;
    endfunction

    // report transfers carry junk in the unused fields
    function automatic pls_pkg::t_in_item report_item(input logic [63:0] junk);
        pls_pkg::t_in_item it;
        it.mode        = pls_pkg::MODE_REPORT;
        it.start_time  = junk;
        it.end_time    = ~junk;
        it.packet_type = junk[1:0];
        it.upstream    = junk[2];
        return it;
    endfunction

    function automatic pls_pkg::t_in_item random_item();
        pls_pkg::t_in_item it;
        logic [63:0] base;
        base           = {$urandom, $urandom};
        it.mode        = ($urandom_range(0, 9) == 0) ? pls_pkg::MODE_REPORT
                                                     : pls_pkg::MODE_RECORD;
        it.start_time  = base;
        it.packet_type = 2'($urandom_range(0, 3));
        it.upstream    = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0:       it.end_time = base + 64'($urandom_range(0, 5000));
            1:       it.end_time = base + {32'd0, $urandom};
            2:       it.end_time = base - 64'($urandom_range(1, 5000));
            3:       it.end_time = base;
            default: it.end_time = {$urandom, $urandom};
        endcase
        return it;
    endfunction

    task automatic send_item(input pls_pkg::t_in_item it);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        board.note_transfer(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    initial begin
        board = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(report_item('0));
        send_item(record_item(64'd0, 64'd0, pls_pkg::PKT_DATA, 1'b1));
        send_item(record_item(64'd0, '1, pls_pkg::PKT_DATA, 1'b1));
        send_item(record_item(64'd100, 64'd150, pls_pkg::PKT_DATA, 1'b1));
        // end before start wraps
        send_item(record_item(64'd10, 64'd3, pls_pkg::PKT_CLOSE, 1'b1));
        send_item(record_item(64'h1_0000_0000, 64'h3_0000_0007, pls_pkg::PKT_CLOSE, 1'b1));
        send_item(record_item('1, '1, pls_pkg::PKT_CLOSE, 1'b1));
        send_item(record_item(64'hFFFF_FFFF_FFFF_FFF0, 64'h10, PKT_OPEN, 1'b1));
        send_item(record_item(64'd5, 64'h8000_0000_0000_0005, PKT_OTHER, 1'b1));
        send_item(record_item(64'h0123_4567_89AB_CDEF, 64'h0123_4567_8A00_0000,
                              PKT_OPEN, 1'b1));
        send_item(record_item(64'd0, 64'd77, pls_pkg::PKT_DATA, 1'b0));
        send_item(record_item(64'd1000, 64'd20, pls_pkg::PKT_CLOSE, 1'b0));
        send_item(record_item('1, 64'd0, PKT_OPEN, 1'b0));
        send_item(record_item(64'h8000_0000_0000_0000, '1, PKT_OTHER, 1'b0));
        send_item(report_item('1));
        send_item(report_item(64'hA5A5_5A5A_C3C3_3C3C));
        send_item(record_item(64'd0, 64'd500, pls_pkg::PKT_DATA, 1'b1));
        send_item(record_item(64'd0, 64'd200, pls_pkg::PKT_DATA, 1'b1));
        send_item(record_item(64'd0, 64'd900, pls_pkg::PKT_DATA, 1'b1));
        send_item(report_item(64'h0000_0000_0000_0004));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  <= 33;
                    recv_stall_pct <= 54;
                end
                1: begin
                    send_idle_pct  <= 54;
                    recv_stall_pct <= 33;
                end
                default: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
            endcase
            repeat (PHASE_ITEMS) send_item(random_item());
            send_item(report_item({$urandom, $urandom}));
            if (phase == 1) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d record and %0d report transfers, %0d class results checked,",
                 board.records_seen, board.reports_seen, board.results_checked);
        $display("across idle/stall mixes on both sides and a full drain mid-run.");
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pls_pkg.sv
hw/rtl/packet_latency_stats_core.sv
bench/packet_latency_stats_core_tb.sv
